### rtl/rthsl_pkg.sv
// ----------------------------------------------------------------------------
// rthsl_pkg
// Shared widths, constants and types for the rgb to hsl pixel pipeline.
// ----------------------------------------------------------------------------
package rthsl_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = PIX_W + 1;
	localparam int HUE_W = 15;
	localparam int SAT_W = 15;
	localparam int QUO_W = 15;
	localparam int DVD_W = PIX_W + QUO_W;

	localparam logic [11:0] HUE_SECTOR = 12'd3840;
	localparam logic [15:0] HUE_FULL = 16'd23040;
	localparam logic [15:0] HUE_GREEN_BASE = 16'd7680;
	localparam logic [15:0] HUE_BLUE_BASE = 16'd15360;
	localparam logic [14:0] SAT_FULL = 15'd25600;
	localparam logic [SUM_W-1:0] HALF_SCALE = 9'd255;
	localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;

	typedef enum logic [1:0] {
		SEL_RED = 2'd0,
		SEL_GREEN = 2'd1,
		SEL_BLUE = 2'd2
	} sel_t;

	typedef struct packed {
		logic [DVD_W-1:0] hue_dvd;
		logic [PIX_W-1:0] hue_dvs;
		logic [DVD_W-1:0] sat_dvd;
		logic [PIX_W-1:0] sat_dvs;
	} div_op_t;

	typedef struct packed {
		sel_t sel;
		logic neg;
		logic zero;
		logic [SUM_W-1:0] sum;
	} side_t;

	typedef struct packed {
		logic [QUO_W-1:0] hue_quo;
		logic [QUO_W-1:0] sat_quo;
		side_t side;
	} div_res_t;

endpackage

### rtl/rthsl_front.sv
// ----------------------------------------------------------------------------
// rthsl_front
// Max/min select and channel difference, then gap, sum, denominator and
// scaled dividends for the two divider lanes.
// ----------------------------------------------------------------------------
module rthsl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        gray,
	input  logic                        in_valid,
	input  logic [rthsl_pkg::PIX_W-1:0] red,
	input  logic [rthsl_pkg::PIX_W-1:0] green,
	input  logic [rthsl_pkg::PIX_W-1:0] blue,
	output logic                        out_valid,
	output rthsl_pkg::div_op_t          op,
	output rthsl_pkg::side_t            side
);

	logic [rthsl_pkg::PIX_W-1:0] r, g, b, mx, mn;
	rthsl_pkg::sel_t             sel;
	logic [rthsl_pkg::PIX_W:0]   d;

	logic                        v_s1;
	logic [rthsl_pkg::PIX_W-1:0] mx_s1, mn_s1;
	rthsl_pkg::sel_t             sel_s1;
	logic [rthsl_pkg::PIX_W:0]   d_s1;

	logic [rthsl_pkg::PIX_W-1:0] gap, den, mag;
	logic [rthsl_pkg::SUM_W-1:0] sum, den_hi;
	logic [rthsl_pkg::PIX_W:0]   d_neg;

	logic                        v_s2;
	rthsl_pkg::div_op_t          op_s2;
	rthsl_pkg::side_t            side_s2;

	// stage 1: extremes and the difference that feeds the hue
	always_comb begin
		r = red;
		g = gray ? red : green;
		b = gray ? red : blue;
		if (r >= g && r >= b) begin
			sel = rthsl_pkg::SEL_RED;
			mx  = r;
			d   = {1'b0, g} - {1'b0, b};
		end else if (g >= b) begin
			sel = rthsl_pkg::SEL_GREEN;
			mx  = g;
			d   = {1'b0, b} - {1'b0, r};
		end else begin
			sel = rthsl_pkg::SEL_BLUE;
			mx  = b;
			d   = {1'b0, r} - {1'b0, g};
		end
		mn = r;
		if (g < mn) begin
			mn = g;
		end
		if (b < mn) begin
			mn = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= mx;
			mn_s1  <= mn;
			sel_s1 <= sel;
			d_s1   <= d;
		end
	end

	// stage 2: gap, lightness sum, saturation denominator, dividends
	always_comb begin
		gap    = mx_s1 - mn_s1;
		sum    = {1'b0, mx_s1} + {1'b0, mn_s1};
		den_hi = rthsl_pkg::SUM_FULL - sum;
		den    = (sum <= rthsl_pkg::HALF_SCALE) ? sum[rthsl_pkg::PIX_W-1:0]
		                                        : den_hi[rthsl_pkg::PIX_W-1:0];
		d_neg  = -d_s1;
		mag    = d_s1[rthsl_pkg::PIX_W] ? d_neg[rthsl_pkg::PIX_W-1:0]
		                                : d_s1[rthsl_pkg::PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2.hue_dvd <= rthsl_pkg::DVD_W'(mag) * rthsl_pkg::DVD_W'(rthsl_pkg::HUE_SECTOR);
			op_s2.hue_dvs <= gap;
			op_s2.sat_dvd <= rthsl_pkg::DVD_W'(gap) * rthsl_pkg::DVD_W'(rthsl_pkg::SAT_FULL);
			op_s2.sat_dvs <= den;
			side_s2.sel   <= sel_s1;
			side_s2.neg   <= d_s1[rthsl_pkg::PIX_W];
			side_s2.zero  <= (gap == '0);
			side_s2.sum   <= sum;
		end
	end

	assign out_valid = v_s2;
	assign op        = op_s2;
	assign side      = side_s2;

endmodule

### rtl/rthsl_div.sv
// ----------------------------------------------------------------------------
// rthsl_div
// Two restoring divider lanes in lockstep, one quotient bit per stage,
// with the sideband carried alongside.
// ----------------------------------------------------------------------------
module rthsl_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rthsl_pkg::div_op_t op,
	input  rthsl_pkg::side_t   side_in,
	output logic               out_valid,
	output rthsl_pkg::div_res_t res
);

	localparam int NST = rthsl_pkg::QUO_W;
	localparam int PW  = rthsl_pkg::PIX_W;
	localparam int QW  = rthsl_pkg::QUO_W;

	logic [NST-1:0]   vld_s;
	logic [PW-1:0]    hrem_s [NST];
	logic [QW-1:0]    hwk_s  [NST];
	logic [PW-1:0]    hdvs_s [NST];
	logic [PW-1:0]    srem_s [NST];
	logic [QW-1:0]    swk_s  [NST];
	logic [PW-1:0]    sdvs_s [NST];
	rthsl_pkg::side_t side_s [NST];

	function automatic logic [PW+QW-1:0] div_step(
		input logic [PW-1:0] rem,
		input logic [QW-1:0] wk,
		input logic [PW-1:0] dvs
	);
		logic [PW:0] sh;
		logic [PW:0] dif;
		logic        ge;
		sh  = {rem, wk[QW-1]};
		dif = sh - {1'b0, dvs};
		ge  = (sh >= {1'b0, dvs});
		return {(ge ? dif[PW-1:0] : sh[PW-1:0]), wk[QW-2:0], ge};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stg
		logic [PW-1:0]    hrem_i, hdvs_i, srem_i, sdvs_i;
		logic [QW-1:0]    hwk_i, swk_i;
		rthsl_pkg::side_t side_i;

		if (k == 0) begin : g_first
			// top dividend bits start as the remainder, already below the divisor
			assign hrem_i = op.hue_dvd[rthsl_pkg::DVD_W-1 -: PW];
			assign hwk_i  = op.hue_dvd[QW-1:0];
			assign hdvs_i = op.hue_dvs;
			assign srem_i = op.sat_dvd[rthsl_pkg::DVD_W-1 -: PW];
			assign swk_i  = op.sat_dvd[QW-1:0];
			assign sdvs_i = op.sat_dvs;
			assign side_i = side_in;
		end else begin : g_next
			assign hrem_i = hrem_s[k-1];
			assign hwk_i  = hwk_s[k-1];
			assign hdvs_i = hdvs_s[k-1];
			assign srem_i = srem_s[k-1];
			assign swk_i  = swk_s[k-1];
			assign sdvs_i = sdvs_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				{hrem_s[k], hwk_s[k]} <= div_step(hrem_i, hwk_i, hdvs_i);
				{srem_s[k], swk_s[k]} <= div_step(srem_i, swk_i, sdvs_i);
				hdvs_s[k] <= hdvs_i;
				sdvs_s[k] <= sdvs_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid   = vld_s[NST-1];
	assign res.hue_quo = hwk_s[NST-1];
	assign res.sat_quo = swk_s[NST-1];
	assign res.side    = side_s[NST-1];

	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] && !side_s[NST-1].zero |->
			hrem_s[NST-1] < hdvs_s[NST-1] && srem_s[NST-1] < sdvs_s[NST-1])
		else $error("divider remainder not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("divider valid bits moved while frozen");

endmodule

### rtl/rthsl_back.sv
// ----------------------------------------------------------------------------
// rthsl_back
// Hue offset and wrap, achromatic override, then output register with a
// skid entry that decouples the output stall from the pipeline.
// ----------------------------------------------------------------------------
module rthsl_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  rthsl_pkg::div_res_t         res,
	output logic                        en,
	output logic                        hsl_valid,
	input  logic                        hsl_stall,
	output logic [rthsl_pkg::HUE_W-1:0] hue_q6,
	output logic [rthsl_pkg::SAT_W-1:0] saturation_q8,
	output logic [rthsl_pkg::SUM_W-1:0] lightness_x2
);

	logic [15:0]                 base, quo, hue_w;
	logic [rthsl_pkg::HUE_W-1:0] hue_n;
	logic [rthsl_pkg::SAT_W-1:0] sat_n;

	logic                        out_v_q, skid_v_q;
	logic [rthsl_pkg::HUE_W-1:0] hue_q, skid_hue_q;
	logic [rthsl_pkg::SAT_W-1:0] sat_q, skid_sat_q;
	logic [rthsl_pkg::SUM_W-1:0] lit_q, skid_lit_q;

	always_comb begin
		case (res.side.sel)
			rthsl_pkg::SEL_GREEN: base = rthsl_pkg::HUE_GREEN_BASE;
			rthsl_pkg::SEL_BLUE:  base = rthsl_pkg::HUE_BLUE_BASE;
			default:              base = '0;
		endcase
		quo = 16'(res.hue_quo);
		if (!res.side.neg) begin
			hue_w = base + quo;
		end else if (quo > base) begin
			// negative red sector hue wraps below 360
			hue_w = rthsl_pkg::HUE_FULL + base - quo;
		end else begin
			hue_w = base - quo;
		end
		hue_n = res.side.zero ? '0 : hue_w[rthsl_pkg::HUE_W-1:0];
		sat_n = res.side.zero ? '0 : res.sat_quo;
	end

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || !hsl_stall) begin
				out_v_q <= skid_v_q || in_valid;
			end
			if (out_v_q && hsl_stall && !skid_v_q && in_valid) begin
				skid_v_q <= 1'b1;
			end else if (out_v_q && !hsl_stall) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !hsl_stall) begin
			hue_q <= skid_v_q ? skid_hue_q : hue_n;
			sat_q <= skid_v_q ? skid_sat_q : sat_n;
			lit_q <= skid_v_q ? skid_lit_q : res.side.sum;
		end
		if (out_v_q && hsl_stall && !skid_v_q) begin
			skid_hue_q <= hue_n;
			skid_sat_q <= sat_n;
			skid_lit_q <= res.side.sum;
		end
	end

	assign hsl_valid     = out_v_q;
	assign hue_q6        = hue_q;
	assign saturation_q8 = sat_q;
	assign lightness_x2  = lit_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && hsl_stall && !skid_v_q && in_valid |=> skid_v_q)
		else $error("transaction dropped on output stall");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> hue_q < rthsl_pkg::HUE_FULL && sat_q <= rthsl_pkg::SAT_FULL)
		else $error("hue or saturation out of range");

endmodule

### rtl/rgb_to_hsl_pixel_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_unit
// Converts one 8-bit rgb pixel per cycle, unless stalled, into fixed point
// hue, saturation and lightness.
//
// channel  direction  handshake              payload
// pix      in         pix_valid / pix_stall  red, green, blue
// hsl      out        hsl_valid / hsl_stall  hue_q6, saturation_q8, lightness_x2
// cfg      in         cfg_valid / cfg_ready  gray_mode
//
// one pixel accepted per cycle while pix_stall is low
// each of the two divider lanes produces one quotient bit per stage
// reset clears all valid bits, the skid entry and gray_mode
// pix_stall is registered: it rises once the output register and skid
// entry both hold a transaction, and the whole pipeline then holds
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic [rthsl_pkg::PIX_W-1:0] red,
	input  logic [rthsl_pkg::PIX_W-1:0] green,
	input  logic [rthsl_pkg::PIX_W-1:0] blue,
	output logic                        hsl_valid,
	input  logic                        hsl_stall,
	output logic [rthsl_pkg::HUE_W-1:0] hue_q6,
	output logic [rthsl_pkg::SAT_W-1:0] saturation_q8,
	output logic [rthsl_pkg::SUM_W-1:0] lightness_x2,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        gray_mode
);

	logic                 en;
	logic                 gray_q;
	logic                 front_valid, div_valid;
	rthsl_pkg::div_op_t   op;
	rthsl_pkg::side_t     side;
	rthsl_pkg::div_res_t  res;

	assign cfg_ready = 1'b1;
	assign pix_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			gray_q <= gray_mode;
		end
	end

	rthsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.gray      (gray_q),
		.in_valid  (pix_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (front_valid),
		.op        (op),
		.side      (side)
	);

	rthsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.op        (op),
		.side_in   (side),
		.out_valid (div_valid),
		.res       (res)
	);

	rthsl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_valid),
		.res           (res),
		.en            (en),
		.hsl_valid     (hsl_valid),
		.hsl_stall     (hsl_stall),
		.hue_q6        (hue_q6),
		.saturation_q8 (saturation_q8),
		.lightness_x2  (lightness_x2)
	);

endmodule
